/* hw/rtl/ini_section_command_tokenizer_top_defines.svh */
// ----------------------------------------------------------------------------
// assertion macros for the ini section/command tokenizer
// ----------------------------------------------------------------------------
`ifndef INI_SECTION_COMMAND_TOKENIZER_TOP_DEFINES_SVH
`define INI_SECTION_COMMAND_TOKENIZER_TOP_DEFINES_SVH

// checked only outside reset
`define IST_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// checked also while reset is applied
`define IST_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

/* hw/rtl/ist_pkg.sv */
// ----------------------------------------------------------------------------
// ist_pkg
// types and constants shared by the tokenizer and its checker
// ----------------------------------------------------------------------------
package ist_pkg;

    localparam int POSITION_BITS_DEF = 20;
    localparam int LINE_BITS_DEF     = 16;

    typedef enum logic [2:0] {
        MODE_IDLE     = 3'd0,
        MODE_COMMENT  = 3'd1,
        MODE_SECTION  = 3'd2,
        MODE_COMMAND  = 3'd3,
        MODE_ARGUMENT = 3'd4
    } mode_t;

    typedef enum logic [1:0] {
        KIND_SECTION  = 2'd0,
        KIND_COMMAND  = 2'd1,
        KIND_ARGUMENT = 2'd2,
        KIND_ERROR    = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ERR_NONE              = 3'd0,
        ERR_CMD_BEFORE_SECT   = 3'd1,
        ERR_BRACKET_EXPECTED  = 3'd2,
        ERR_ARROW_EXPECTED    = 3'd3,
        ERR_CLOSE_EXPECTED    = 3'd4,
        ERR_ARROW_IN_COMMAND  = 3'd5
    } err_t;

    localparam logic [7:0] CHAR_HASH    = 8'h23;
    localparam logic [7:0] CHAR_LBRACK  = 8'h5B;
    localparam logic [7:0] CHAR_RBRACK  = 8'h5D;
    localparam logic [7:0] CHAR_ARROW   = 8'h3E;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [7:0] CHAR_TAB     = 8'h09;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;

endpackage

/* hw/rtl/ini_section_command_tokenizer_top.sv */
// ----------------------------------------------------------------------------
// ini_section_command_tokenizer_top
// a byte accepted into the input register has its token (if any) loaded into
// the result register once free; throughput: one byte per cycle while m_ready
// drains the result register, set by the single mode/offset update per byte
// reset: synchronous active low; clears mode, offsets, line count, flags, valids
// after a syntax error the block swallows bytes without results until reset
// ----------------------------------------------------------------------------
module ini_section_command_tokenizer_top #(
    parameter int POSITION_BITS = ist_pkg::POSITION_BITS_DEF,
    parameter int LINE_BITS     = ist_pkg::LINE_BITS_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    // byte input
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [7:0]               s_data_byte,
    // token output
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [1:0]               m_result_kind,
    output logic [2:0]               m_error_code,
    output logic [POSITION_BITS-1:0] m_name_start,
    output logic [POSITION_BITS-1:0] m_name_length,
    output logic [LINE_BITS-1:0]     m_line_number
);
    import ist_pkg::*;

    localparam logic [LINE_BITS-1:0] LINE_MAX = '1;

    // input register stage
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;

    // parser state
    mode_t                    mode_reg, mode_next;
    logic [POSITION_BITS-1:0] byte_pos_reg, byte_pos_next;
    logic [POSITION_BITS-1:0] token_start_reg, token_start_next;
    logic                     token_started_reg, token_started_next;
    logic [LINE_BITS-1:0]     line_count_reg, line_count_next;
    logic                     seen_section_reg, seen_section_next;
    logic                     seen_command_reg, seen_command_next;
    logic                     halted_reg, halted_next;

    // result register
    logic                     m_valid_reg;
    kind_t                    m_kind_reg;
    err_t                     m_code_reg;
    logic [POSITION_BITS-1:0] m_start_reg;
    logic [POSITION_BITS-1:0] m_len_reg;
    logic [LINE_BITS-1:0]     m_line_reg;

    // result of the byte in the input register
    logic                     res_valid;
    kind_t                    res_kind;
    err_t                     res_code;
    logic [POSITION_BITS-1:0] res_start;
    logic [POSITION_BITS-1:0] res_len;
    logic [LINE_BITS-1:0]     res_line;

    logic                     out_free;
    logic                     advance;
    logic                     work;
    logic                     is_nl, is_blank, is_hash, is_lbrack, is_rbrack, is_arrow;
    logic [LINE_BITS-1:0]     line_inc;
    logic [POSITION_BITS-1:0] close_start;
    logic [POSITION_BITS-1:0] close_len;

    // handshake: the result register is free when empty or being drained,
    // and the input register moves on whenever the result register is free
    assign out_free = !m_valid_reg || m_ready;
    assign advance  = in_valid_reg && out_free;
    assign work     = advance && !halted_reg;
    assign s_ready  = !in_valid_reg || out_free;

    // byte classes
    assign is_nl     = (in_byte_reg == CHAR_NEWLINE);
    assign is_blank  = (in_byte_reg == CHAR_SPACE) || (in_byte_reg == CHAR_TAB);
    assign is_hash   = (in_byte_reg == CHAR_HASH);
    assign is_lbrack = (in_byte_reg == CHAR_LBRACK);
    assign is_rbrack = (in_byte_reg == CHAR_RBRACK);
    assign is_arrow  = (in_byte_reg == CHAR_ARROW);

    // saturating line counter
    assign line_inc = (line_count_reg == LINE_MAX) ? line_count_reg
                                                   : line_count_reg + 1'b1;

    // a name that never got a byte starts at the closing byte, length zero
    assign close_start = token_started_reg ? token_start_reg : byte_pos_reg;
    assign close_len   = byte_pos_reg - close_start;

    // next mode
    always_comb begin
        mode_next = mode_reg;
        if (work) begin
            case (mode_reg)
                MODE_IDLE: begin
                    if (is_hash) begin
                        mode_next = MODE_COMMENT;
                    end else if (is_lbrack) begin
                        mode_next = MODE_SECTION;
                    end else if (is_arrow) begin
                        if (seen_section_reg) begin
                            mode_next = MODE_COMMAND;
                        end
                    end else if (!is_nl && !is_blank && seen_section_reg
                                 && seen_command_reg) begin
                        mode_next = MODE_ARGUMENT;
                    end
                end
                MODE_COMMENT: begin
                    if (is_nl) begin
                        mode_next = MODE_IDLE;
                    end
                end
                MODE_SECTION: begin
                    if (is_rbrack) begin
                        mode_next = MODE_IDLE;
                    end
                end
                MODE_COMMAND: begin
                    if (is_nl || is_blank) begin
                        mode_next = MODE_IDLE;
                    end
                end
                MODE_ARGUMENT: begin
                    if (is_nl) begin
                        mode_next = MODE_IDLE;
                    end else if (is_hash) begin
                        mode_next = MODE_COMMENT;
                    end
                end
                default: begin
                    mode_next = MODE_IDLE;
                end
            endcase
        end
    end

    // datapath updates and token/error result
    always_comb begin
        byte_pos_next      = byte_pos_reg;
        token_start_next   = token_start_reg;
        token_started_next = token_started_reg;
        line_count_next    = line_count_reg;
        seen_section_next  = seen_section_reg;
        seen_command_next  = seen_command_reg;
        halted_next        = halted_reg;
        res_valid          = 1'b0;
        res_kind           = KIND_SECTION;
        res_code           = ERR_NONE;
        res_start          = close_start;
        res_len            = close_len;
        res_line           = line_count_reg;
        if (work) begin
            byte_pos_next = byte_pos_reg + 1'b1;
            case (mode_reg)
                MODE_IDLE: begin
                    if (is_arrow) begin
                        if (!seen_section_reg) begin
                            res_valid = 1'b1;
                            res_kind  = KIND_ERROR;
                            res_code  = ERR_CMD_BEFORE_SECT;
                        end
                    end else if (is_nl) begin
                        line_count_next = line_inc;
                    end else if (!is_hash && !is_lbrack && !is_blank) begin
                        // argument text starts here, if the context allows it
                        if (!seen_section_reg) begin
                            res_valid = 1'b1;
                            res_kind  = KIND_ERROR;
                            res_code  = ERR_BRACKET_EXPECTED;
                        end else if (!seen_command_reg) begin
                            res_valid = 1'b1;
                            res_kind  = KIND_ERROR;
                            res_code  = ERR_ARROW_EXPECTED;
                        end else begin
                            token_start_next   = byte_pos_reg;
                            token_started_next = 1'b1;
                        end
                    end
                end
                MODE_COMMENT: begin
                    if (is_nl) begin
                        line_count_next = line_inc;
                    end
                end
                MODE_SECTION: begin
                    if (is_nl) begin
                        // unterminated section reports the line after the bump
                        line_count_next = line_inc;
                        res_valid       = 1'b1;
                        res_kind        = KIND_ERROR;
                        res_code        = ERR_CLOSE_EXPECTED;
                        res_line        = line_inc;
                    end else if (is_rbrack) begin
                        res_valid          = 1'b1;
                        res_kind           = KIND_SECTION;
                        token_started_next = 1'b0;
                        seen_section_next  = 1'b1;
                    end else if (!token_started_reg) begin
                        token_start_next   = byte_pos_reg;
                        token_started_next = 1'b1;
                    end
                end
                MODE_COMMAND: begin
                    if (is_nl || is_blank) begin
                        if (is_nl) begin
                            line_count_next = line_inc;
                        end
                        res_valid          = 1'b1;
                        res_kind           = KIND_COMMAND;
                        token_started_next = 1'b0;
                        seen_command_next  = 1'b1;
                    end else if (is_arrow) begin
                        res_valid = 1'b1;
                        res_kind  = KIND_ERROR;
                        res_code  = ERR_ARROW_IN_COMMAND;
                    end else if (!token_started_reg) begin
                        token_start_next   = byte_pos_reg;
                        token_started_next = 1'b1;
                    end
                end
                MODE_ARGUMENT: begin
                    if (is_nl || is_hash) begin
                        if (is_nl) begin
                            line_count_next = line_inc;
                        end
                        res_valid          = 1'b1;
                        res_kind           = KIND_ARGUMENT;
                        token_started_next = 1'b0;
                    end
                end
                default: begin
                end
            endcase
            // errors carry no name and stop all further parsing
            if (res_kind == KIND_ERROR) begin
                res_start   = '0;
                res_len     = '0;
                halted_next = 1'b1;
            end
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_data_byte;
        end
    end

    // parser state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg          <= MODE_IDLE;
            byte_pos_reg      <= '0;
            token_start_reg   <= '0;
            token_started_reg <= 1'b0;
            line_count_reg    <= '0;
            seen_section_reg  <= 1'b0;
            seen_command_reg  <= 1'b0;
            halted_reg        <= 1'b0;
        end else begin
            mode_reg          <= mode_next;
            byte_pos_reg      <= byte_pos_next;
            token_start_reg   <= token_start_next;
            token_started_reg <= token_started_next;
            line_count_reg    <= line_count_next;
            seen_section_reg  <= seen_section_next;
            seen_command_reg  <= seen_command_next;
            halted_reg        <= halted_next;
        end
    end

    // result register: loads whenever free, so an empty slot drops out
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && res_valid) begin
            m_kind_reg  <= res_kind;
            m_code_reg  <= res_code;
            m_start_reg <= res_start;
            m_len_reg   <= res_len;
            m_line_reg  <= res_line;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_result_kind = m_kind_reg;
    assign m_error_code  = m_code_reg;
    assign m_name_start  = m_start_reg;
    assign m_name_length = m_len_reg;
    assign m_line_number = m_line_reg;

endmodule

/* hw/rtl/ist_checker.sv */
// ----------------------------------------------------------------------------
// ist_checker
// port-level checks on the tokenizer, bound to the top level
// ----------------------------------------------------------------------------
`include "ini_section_command_tokenizer_top_defines.svh"

module ist_checker #(
    parameter int POSITION_BITS = ist_pkg::POSITION_BITS_DEF,
    parameter int LINE_BITS     = ist_pkg::LINE_BITS_DEF
) (
    input logic                     aclk,
    input logic                     aresetn,
    input logic                     m_valid,
    input logic                     m_ready,
    input logic [1:0]               m_result_kind,
    input logic [2:0]               m_error_code,
    input logic [POSITION_BITS-1:0] m_name_start,
    input logic [POSITION_BITS-1:0] m_name_length,
    input logic [LINE_BITS-1:0]     m_line_number
);
    import ist_pkg::*;

    logic err_seen_reg;
    logic is_err;

    assign is_err = (m_result_kind == KIND_ERROR);

    // an error item has gone out
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            err_seen_reg <= 1'b0;
        end else if (m_valid && m_ready && is_err) begin
            err_seen_reg <= 1'b1;
        end
    end

    `IST_ASSERT_RST(a_reset_clears_out, !aresetn |=> !m_valid, "result valid after reset")
    `IST_ASSERT(a_halt_after_error, err_seen_reg |-> !m_valid, "result after an error")
    `IST_ASSERT(a_error_no_name, m_valid && is_err |-> m_name_start == '0 && m_name_length == '0, "error item carries a name")
    `IST_ASSERT(a_token_no_code, m_valid && !is_err |-> m_error_code == ERR_NONE, "token item carries an error code")
    `IST_ASSERT(a_out_hold, m_valid && !m_ready |=> m_valid && $stable(m_name_start) && $stable(m_line_number), "stalled result changed")

endmodule

bind ini_section_command_tokenizer_top ist_checker #(
    .POSITION_BITS(POSITION_BITS),
    .LINE_BITS(LINE_BITS)
) u_ist_checker (.*);
